// ----- sv/ray_ellipsoid_intersection_defines.svh -----
`ifndef RAY_ELLIPSOID_INTERSECTION_DEFINES_SVH
`define RAY_ELLIPSOID_INTERSECTION_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define REI_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication a fixed number of cycles later
`define REI_ASSERT_LATER(label, ante, dly, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

// ----- sv/rei_pkg.sv -----
`default_nettype none
package rei_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;

	// wide multiplier: 64x64 signed operands, 128-bit product
	localparam int MUL_W   = 64;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int MUL_LAT = 4;

	// normalized coefficient width
	localparam int CS_W = 62;

	// square root: one result bit per stage, det below 2^124
	localparam int SQ_STEPS = 62;

	// divider: one range stage, then one quotient bit per stage
	localparam int DIV_STEPS = 63;
	localparam int DIV_LAT   = DIV_STEPS + 1;

	typedef enum logic [2:0] {
		REG_RADIUS   = 3'd0,
		REG_SCALE_Y  = 3'd1,
		REG_SCALE_Z  = 3'd2,
		REG_CENTER_X = 3'd3,
		REG_CENTER_Y = 3'd4,
		REG_CENTER_Z = 3'd5
	} reg_idx_t;

endpackage
`default_nettype wire

// ----- sv/ray_ellipsoid_intersection.sv -----
`default_nettype none
// Channel   Ports                                        Handshake
// request   origin_*, dir_*, take_smaller_root           start, taken when busy is low
// result    hit, point_*, saturated                      done, one cycle, no back-pressure
// config    psel penable pwrite paddr pwdata prdata      APB, pready tied high
//
// Fully pipelined: one request per cycle, busy never rises.
// A request passes the coefficient stages, the 62-stage square root, the numerator
// multipliers and the 64-stage divider; done is registered together with the result.
// Reset clears only the valid line and the registers; payload stages are not reset.
// Results cannot be stalled, so the pipeline advances every cycle.
module ray_ellipsoid_intersection import rei_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,

	input  wire logic                          start,
	output logic                               busy,
	input  wire logic signed [COORD_WIDTH-1:0] origin_x,
	input  wire logic signed [COORD_WIDTH-1:0] origin_y,
	input  wire logic signed [COORD_WIDTH-1:0] origin_z,
	input  wire logic signed [COORD_WIDTH-1:0] dir_x,
	input  wire logic signed [COORD_WIDTH-1:0] dir_y,
	input  wire logic signed [COORD_WIDTH-1:0] dir_z,
	input  wire logic                          take_smaller_root,

	output logic                               done,
	output logic                               hit,
	output logic signed [COORD_WIDTH-1:0]      point_x,
	output logic signed [COORD_WIDTH-1:0]      point_y,
	output logic signed [COORD_WIDTH-1:0]      point_z,
	output logic                               saturated,

	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [$clog2(6*((COORD_WIDTH > 32) ? 8 : 4))-1:0] paddr,
	input  wire logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0]        pwdata,
	output logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0]             prdata,
	output logic                               pready
);

	`include "ray_ellipsoid_intersection_defines.svh"

	localparam int CW     = COORD_WIDTH;
	localparam int DW     = (CW > 32) ? 64 : 32;
	localparam int BSH    = (CW > 32) ? 3 : 2;
	localparam int ADDR_W = $clog2(6 * (DW / 8));
	localparam int PW     = CW + 33;
	localparam int EW     = (PW > 64) ? PW : 64;
	localparam int SQ_DW  = 2 * SQ_STEPS;
	localparam int SQ_RW  = SQ_STEPS + 2;

	// stage numbers, counted from the accepting edge
	localparam int ST_CS  = 13;
	localparam int ST_DET = ST_CS + MUL_LAT + 1;
	localparam int ST_SQ  = ST_DET + SQ_STEPS;
	localparam int ST_N   = ST_SQ + 1;
	localparam int ST_NUM = ST_N + MUL_LAT;
	localparam int ST_Q   = ST_NUM + DIV_LAT;
	localparam int ST_OUT = ST_Q + 1;

	localparam logic signed [63:0] PMAX  = (64'sd1 <<< (CW - 1)) - 64'sd1;
	localparam logic signed [63:0] PMIN  = -PMAX - 64'sd1;
	localparam logic [DIV_STEPS-1:0] Q_LIM = DIV_STEPS'(64'd1 << 62);

	typedef struct packed {
		logic [2:0][CW-1:0] o;
		logic [2:0][CW-1:0] v;
		logic               sel;
	} ray_t;

	// ---------------- configuration ----------------
	logic [30:0]   radius_q, scale_y_q, scale_z_q;
	logic [CW-1:0] center_q [3];
	reg_idx_t      widx, ridx;

	assign pready = 1'b1;
	assign widx   = reg_idx_t'(paddr[ADDR_W-1:BSH]);
	assign ridx   = widx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q    <= 31'(64'd1 << FRAC_BITS);
			scale_y_q   <= 31'(64'd1 << FRAC_BITS);
			scale_z_q   <= 31'(64'd1 << FRAC_BITS);
			center_q[0] <= '0;
			center_q[1] <= '0;
			center_q[2] <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (widx)
				REG_RADIUS:   radius_q    <= pwdata[30:0];
				REG_SCALE_Y:  scale_y_q   <= pwdata[30:0];
				REG_SCALE_Z:  scale_z_q   <= pwdata[30:0];
				REG_CENTER_X: center_q[0] <= pwdata[CW-1:0];
				REG_CENTER_Y: center_q[1] <= pwdata[CW-1:0];
				REG_CENTER_Z: center_q[2] <= pwdata[CW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_RADIUS:   prdata = DW'(radius_q);
			REG_SCALE_Y:  prdata = DW'(scale_y_q);
			REG_SCALE_Z:  prdata = DW'(scale_z_q);
			REG_CENTER_X: prdata = DW'($signed(center_q[0]));
			REG_CENTER_Y: prdata = DW'($signed(center_q[1]));
			REG_CENTER_Z: prdata = DW'($signed(center_q[2]));
			default:      prdata = '0;
		endcase
	end

	// ---------------- request line ----------------
	logic         accept;
	logic [ST_Q-1:0] vld_s;
	ray_t         ray_s [ST_Q];

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[ST_Q-2:0], accept};
		end
	end

	always_ff @(posedge clk) begin
		ray_s[0].o   <= {origin_z, origin_y, origin_x};
		ray_s[0].v   <= {dir_z, dir_y, dir_x};
		ray_s[0].sel <= take_smaller_root;
		for (int i = 1; i < ST_Q; i++) begin
			ray_s[i] <= ray_s[i-1];
		end
	end

	// ---------------- scaled terms ----------------
	function automatic logic signed [PW-1:0] scale_mul(input logic [30:0] s,
			input logic signed [CW:0] x);
		logic signed [PW-1:0] sa, xa;
		sa = $signed(PW'(s));
		xa = PW'(x);
		return sa * xa;
	endfunction

	// floor shift, then clamp to [-2^62, 2^62)
	function automatic logic signed [63:0] clamp_term(input logic signed [PW-1:0] p);
		logic signed [EW-1:0] e;
		e = EW'(p);
		e = e >>> FRAC_BITS;
		if ((&e[EW-1:62]) || !(|e[EW-1:62])) begin
			return e[63:0];
		end else if (e[EW-1]) begin
			return 64'shC000_0000_0000_0000;
		end else begin
			return 64'sh3FFF_FFFF_FFFF_FFFF;
		end
	endfunction

	logic signed [CW:0]    d_s2 [3];
	logic signed [PW-1:0]  sp_s3 [4];
	logic signed [CW-1:0]  a0_s3;
	logic signed [CW:0]    b0_s3;
	logic signed [63:0]    a_s4 [3];
	logic signed [63:0]    b_s4 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			d_s2[i] <= $signed({ray_s[0].o[i][CW-1], ray_s[0].o[i]})
				- $signed({center_q[i][CW-1], center_q[i]});
		end

		sp_s3[0] <= scale_mul(scale_y_q, $signed({ray_s[1].v[1][CW-1], ray_s[1].v[1]}));
		sp_s3[1] <= scale_mul(scale_y_q, d_s2[1]);
		sp_s3[2] <= scale_mul(scale_z_q, $signed({ray_s[1].v[2][CW-1], ray_s[1].v[2]}));
		sp_s3[3] <= scale_mul(scale_z_q, d_s2[2]);
		a0_s3    <= $signed(ray_s[1].v[0]);
		b0_s3    <= d_s2[0];

		a_s4[0] <= 64'(a0_s3);
		b_s4[0] <= 64'(b0_s3);
		a_s4[1] <= clamp_term(sp_s3[0]);
		b_s4[1] <= clamp_term(sp_s3[1]);
		a_s4[2] <= clamp_term(sp_s3[2]);
		b_s4[2] <= clamp_term(sp_s3[3]);
	end

	// ---------------- coefficient products ----------------
	logic signed [MUL_W-1:0]  cm_a [10];
	logic signed [MUL_W-1:0]  cm_b [10];
	logic signed [PROD_W-1:0] cm_p [10];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cm_a[i]   = a_s4[i];
			cm_b[i]   = a_s4[i];
			cm_a[3+i] = a_s4[i];
			cm_b[3+i] = b_s4[i];
			cm_a[6+i] = b_s4[i];
			cm_b[6+i] = b_s4[i];
		end
		cm_a[9] = MUL_W'(radius_q);
		cm_b[9] = MUL_W'(radius_q);
	end

	for (genvar g = 0; g < 10; g++) begin : g_cmul
		rei_mul u_mul (.clk(clk), .a(cm_a[g]), .b(cm_b[g]), .p(cm_p[g]));
	end

	logic signed [PROD_W-1:0] c_s9  [3];
	logic signed [PROD_W-1:0] c_s10 [3];
	logic signed [PROD_W-1:0] c_s11 [3];
	logic signed [PROD_W-1:0] c_s12 [3];
	logic [15:0]              nz_s10;
	logic [2:0]               hi_s10 [16];
	logic [6:0]               k_s11;
	logic [2:0]               kf_s12;
	logic [PROD_W-1:0]        sig_m;
	logic [15:0]              nz_c;
	logic [2:0]               hi_c [16];
	logic [6:0]               top_c, k_c;

	// bits that differ from the sign, over all three coefficients
	always_comb begin
		sig_m = (c_s9[0] ^ {PROD_W{c_s9[0][PROD_W-1]}})
			| (c_s9[1] ^ {PROD_W{c_s9[1][PROD_W-1]}})
			| (c_s9[2] ^ {PROD_W{c_s9[2][PROD_W-1]}});
		sig_m[PROD_W-1] = 1'b0;
		for (int ch = 0; ch < 16; ch++) begin
			nz_c[ch] = |sig_m[ch*8 +: 8];
			hi_c[ch] = 3'd0;
			for (int b = 0; b < 8; b++) begin
				if (sig_m[ch*8+b]) begin
					hi_c[ch] = 3'(b);
				end
			end
		end
	end

	always_comb begin
		top_c = 7'd0;
		for (int ch = 0; ch < 16; ch++) begin
			if (nz_s10[ch]) begin
				top_c = {4'(ch), hi_s10[ch]};
			end
		end
		k_c = (top_c > 7'd60) ? (top_c - 7'd60) : 7'd0;
	end

	always_ff @(posedge clk) begin
		c_s9[0] <= cm_p[0] + cm_p[1] + cm_p[2];
		c_s9[1] <= cm_p[3] + cm_p[4] + cm_p[5];
		c_s9[2] <= cm_p[6] + cm_p[7] + cm_p[8] - cm_p[9];

		c_s10  <= c_s9;
		nz_s10 <= nz_c;
		hi_s10 <= hi_c;

		c_s11 <= c_s10;
		k_s11 <= k_c;

		for (int i = 0; i < 3; i++) begin
			c_s12[i] <= c_s11[i] >>> {k_s11[6:3], 3'b000};
		end
		kf_s12 <= k_s11[2:0];
	end

	// ---------------- normalized coefficients, discriminant ----------------
	localparam int CS_LEN = ST_NUM - ST_CS + 1;

	logic signed [CS_W-1:0] c1s_s [CS_LEN];
	logic signed [CS_W-1:0] c2s_s [CS_LEN];
	logic signed [CS_W-1:0] c3s_s13;
	logic signed [PROD_W-1:0] sh_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sh_c[i] = c_s12[i] >>> kf_s12;
		end
	end

	always_ff @(posedge clk) begin
		c1s_s[0] <= sh_c[0][CS_W-1:0];
		c2s_s[0] <= sh_c[1][CS_W-1:0];
		c3s_s13  <= sh_c[2][CS_W-1:0];
		for (int i = 1; i < CS_LEN; i++) begin
			c1s_s[i] <= c1s_s[i-1];
			c2s_s[i] <= c2s_s[i-1];
		end
	end

	logic signed [PROD_W-1:0] dp_sq, dp_ac;

	rei_mul u_mul_bb (.clk(clk), .a(MUL_W'(c2s_s[0])), .b(MUL_W'(c2s_s[0])), .p(dp_sq));
	rei_mul u_mul_ac (.clk(clk), .a(MUL_W'(c1s_s[0])), .b(MUL_W'(c3s_s13)), .p(dp_ac));

	localparam int MISS_LEN = ST_Q - ST_DET + 1;

	logic                   miss_s [MISS_LEN];
	logic signed [PROD_W-1:0] det_c;

	assign det_c = dp_sq - dp_ac;

	always_ff @(posedge clk) begin
		miss_s[0] <= (c1s_s[ST_DET-1-ST_CS] == '0) || det_c[PROD_W-1];
		for (int i = 1; i < MISS_LEN; i++) begin
			miss_s[i] <= miss_s[i-1];
		end
	end

	// ---------------- square root, one bit per stage ----------------
	logic [SQ_RW-1:0]    sq_rem_s  [SQ_STEPS+1];
	logic [SQ_STEPS-1:0] sq_root_s [SQ_STEPS+1];
	logic [SQ_DW-1:0]    sq_det_s  [SQ_STEPS+1];

	always_ff @(posedge clk) begin
		sq_rem_s[0]  <= '0;
		sq_root_s[0] <= '0;
		sq_det_s[0]  <= det_c[SQ_DW-1:0];
	end

	for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
		logic [SQ_RW+1:0] r2, trial;
		logic             ge;

		always_comb begin
			r2    = {sq_rem_s[j], sq_det_s[j][SQ_DW-1 -: 2]};
			trial = {{(SQ_RW-SQ_STEPS){1'b0}}, sq_root_s[j], 2'b01};
			ge    = r2 >= trial;
		end

		always_ff @(posedge clk) begin
			sq_rem_s[j+1]  <= ge ? SQ_RW'(r2 - trial) : SQ_RW'(r2);
			sq_root_s[j+1] <= {sq_root_s[j][SQ_STEPS-2:0], ge};
			sq_det_s[j+1]  <= {sq_det_s[j][SQ_DW-3:0], 2'b00};
		end
	end

	// ---------------- root select, numerators ----------------
	localparam int QN_LEN = ST_Q - ST_N + 1;

	logic signed [63:0] n_c, c2s_ext, root_ext;
	logic [63:0]        nmag_s81;
	logic [63:0]        vmag_s81 [3];
	logic [2:0]         qneg_s [QN_LEN];
	logic signed [63:0] vext_c [3];

	always_comb begin
		c2s_ext  = 64'(c2s_s[ST_SQ-ST_CS]);
		root_ext = $signed(64'(sq_root_s[SQ_STEPS]));
		n_c = ray_s[ST_SQ-1].sel ? (-c2s_ext - root_ext) : (-c2s_ext + root_ext);
		for (int i = 0; i < 3; i++) begin
			vext_c[i] = 64'($signed(ray_s[ST_SQ-1].v[i]));
		end
	end

	always_ff @(posedge clk) begin
		nmag_s81 <= n_c[63] ? (~n_c + 1'b1) : n_c;
		for (int i = 0; i < 3; i++) begin
			vmag_s81[i]  <= vext_c[i][63] ? (~vext_c[i] + 1'b1) : vext_c[i];
			qneg_s[0][i] <= vext_c[i][63] ^ n_c[63];
		end
		for (int i = 1; i < QN_LEN; i++) begin
			qneg_s[i] <= qneg_s[i-1];
		end
	end

	logic signed [PROD_W-1:0] num_p [3];
	logic [DIV_STEPS-1:0]     quo   [3];
	logic [2:0]               ovf;

	for (genvar g = 0; g < 3; g++) begin : g_lane
		rei_mul u_mul_num (
			.clk(clk),
			.a  ($signed(vmag_s81[g])),
			.b  ($signed(nmag_s81)),
			.p  (num_p[g])
		);
		rei_udiv u_div (
			.clk(clk),
			.num(num_p[g]),
			.den(c1s_s[ST_NUM-ST_CS]),
			.quo(quo[g]),
			.ovf(ovf[g])
		);
	end

	// ---------------- final add, saturate ----------------
	logic signed [CW-1:0] pt_c [3];
	logic [2:0]           sat_c;
	logic [DIV_STEPS-1:0] qc   [3];
	logic signed [63:0]   qs   [3];
	logic signed [63:0]   sum_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qc[i]    = (ovf[i] || quo[i] > Q_LIM) ? Q_LIM : quo[i];
			qs[i]    = qneg_s[QN_LEN-1][i] ? -$signed(64'(qc[i])) : $signed(64'(qc[i]));
			sum_c[i] = 64'($signed(ray_s[ST_Q-1].o[i])) + qs[i];
			sat_c[i] = 1'b0;
			pt_c[i]  = sum_c[i][CW-1:0];
			if (sum_c[i] > PMAX) begin
				pt_c[i]  = PMAX[CW-1:0];
				sat_c[i] = 1'b1;
			end else if (sum_c[i] < PMIN) begin
				pt_c[i]  = PMIN[CW-1:0];
				sat_c[i] = 1'b1;
			end
		end
	end

	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s[ST_Q-1];
		end
	end

	always_ff @(posedge clk) begin
		if (miss_s[MISS_LEN-1]) begin
			hit       <= 1'b0;
			point_x   <= '0;
			point_y   <= '0;
			point_z   <= '0;
			saturated <= 1'b0;
		end else begin
			hit       <= 1'b1;
			point_x   <= pt_c[0];
			point_y   <= pt_c[1];
			point_z   <= pt_c[2];
			saturated <= |sat_c;
		end
	end

	assign done = done_q;

	// ---------------- checks ----------------
	`REI_ASSERT_LATER(a_latency, start && !busy, ST_OUT, done, "request lost in pipeline")
	`REI_ASSERT_SAME(a_no_phantom, done, $past(start && !busy, ST_OUT), "result without request")
	`REI_ASSERT_SAME(a_miss_zero, done && !hit, point_x == '0 && point_y == '0 && point_z == '0 && !saturated, "miss result not cleared")
	`REI_ASSERT_SAME(a_sat_hit, done && saturated, hit, "saturation flagged on a miss")

endmodule
`default_nettype wire

// ----- sv/rei_mul.sv -----
`default_nettype none
module rei_mul import rei_pkg::*; (
	input  wire logic                     clk,
	input  wire logic signed [MUL_W-1:0]  a,
	input  wire logic signed [MUL_W-1:0]  b,
	output logic signed [PROD_W-1:0]      p
);

	localparam int HW = MUL_W / 2;

	logic [MUL_W-1:0]  ma_s1, mb_s1;
	logic              neg_s1, neg_s2, neg_s3;
	logic [MUL_W-1:0]  pp_s2 [4];
	logic [PROD_W-1:0] sum_s3;
	logic [PROD_W-1:0] p_s4;

	always_ff @(posedge clk) begin
		ma_s1  <= a[MUL_W-1] ? (~a + 1'b1) : a;
		mb_s1  <= b[MUL_W-1] ? (~b + 1'b1) : b;
		neg_s1 <= a[MUL_W-1] ^ b[MUL_W-1];

		pp_s2[0] <= ma_s1[HW-1:0]     * mb_s1[HW-1:0];
		pp_s2[1] <= ma_s1[HW-1:0]     * mb_s1[MUL_W-1:HW];
		pp_s2[2] <= ma_s1[MUL_W-1:HW] * mb_s1[HW-1:0];
		pp_s2[3] <= ma_s1[MUL_W-1:HW] * mb_s1[MUL_W-1:HW];
		neg_s2   <= neg_s1;

		sum_s3 <= {{MUL_W{1'b0}}, pp_s2[0]}
			+ {{HW{1'b0}}, pp_s2[1], {HW{1'b0}}}
			+ {{HW{1'b0}}, pp_s2[2], {HW{1'b0}}}
			+ {pp_s2[3], {MUL_W{1'b0}}};
		neg_s3 <= neg_s2;

		p_s4 <= neg_s3 ? (~sum_s3 + 1'b1) : sum_s3;
	end

	assign p = $signed(p_s4);

endmodule
`default_nettype wire

// ----- sv/rei_udiv.sv -----
`default_nettype none
module rei_udiv import rei_pkg::*; (
	input  wire logic                  clk,
	input  wire logic [PROD_W-1:0]     num,
	input  wire logic [CS_W-1:0]       den,
	output logic [DIV_STEPS-1:0]       quo,
	output logic                       ovf
);

	localparam int HI_W = PROD_W - DIV_STEPS;

	logic [CS_W-1:0]      rem_s [DIV_STEPS+1];
	logic [DIV_STEPS-1:0] low_s [DIV_STEPS+1];
	logic [CS_W-1:0]      den_s [DIV_STEPS+1];
	logic [DIV_STEPS-1:0] quo_s [DIV_STEPS+1];
	logic                 ovf_s [DIV_STEPS+1];

	// quotient of 2^63 or more is flagged; otherwise the upper part is the first remainder
	always_ff @(posedge clk) begin
		ovf_s[0] <= num[PROD_W-1:DIV_STEPS] >= HI_W'(den);
		rem_s[0] <= num[DIV_STEPS+CS_W-1:DIV_STEPS];
		low_s[0] <= num[DIV_STEPS-1:0];
		den_s[0] <= den;
		quo_s[0] <= '0;
	end

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
		logic [CS_W:0] r2;
		logic          ge;

		always_comb begin
			r2 = {rem_s[j], low_s[j][DIV_STEPS-1]};
			ge = r2 >= {1'b0, den_s[j]};
		end

		always_ff @(posedge clk) begin
			rem_s[j+1] <= ge ? CS_W'(r2 - {1'b0, den_s[j]}) : CS_W'(r2);
			low_s[j+1] <= {low_s[j][DIV_STEPS-2:0], 1'b0};
			den_s[j+1] <= den_s[j];
			quo_s[j+1] <= {quo_s[j][DIV_STEPS-2:0], ge};
			ovf_s[j+1] <= ovf_s[j];
		end
	end

	assign quo = quo_s[DIV_STEPS];
	assign ovf = ovf_s[DIV_STEPS];

endmodule
`default_nettype wire

// ----- sim/ray_ellipsoid_intersection_test.sv -----
`default_nettype none
module ray_ellipsoid_intersection_test import rei_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 16;
	localparam int ONE = 1 << FRAC;
	localparam int UNMAPPED_INDEX = 6;
	localparam int DRAIN_CYCLES = 170;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic signed [127:0] TERM_MAX = (128'sd1 <<< 62) - 1;
	localparam logic signed [127:0] TERM_MIN = -(128'sd1 <<< 62);
	localparam logic signed [127:0] NORM_LIM = 128'sd1 <<< 61;
	localparam logic signed [127:0] COORD_MAX = 128'sd2147483647;
	localparam logic signed [127:0] COORD_MIN = -128'sd2147483648;

	typedef struct packed {
		logic signed [31:0] ox, oy, oz, dx, dy, dz;
		logic smaller;
	} ray_t;

	typedef struct packed {
		logic hit;
		logic signed [31:0] px, py, pz;
		logic sat;
	} point_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic signed [31:0] origin_x = 0, origin_y = 0, origin_z = 0;
	logic signed [31:0] dir_x = 0, dir_y = 0, dir_z = 0;
	logic take_smaller_root = 0;
	logic done, hit, saturated;
	logic signed [31:0] point_x, point_y, point_z;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [4:0] paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic pready;

	ray_ellipsoid_intersection u_top (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy),
		.origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
		.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
		.take_smaller_root(take_smaller_root),
		.done(done), .hit(hit),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.saturated(saturated),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// shadow of the configuration registers
	logic [30:0] cfg_radius = 31'(ONE);
	logic [30:0] cfg_scale_y = 31'(ONE);
	logic [30:0] cfg_scale_z = 31'(ONE);
	logic signed [31:0] cfg_center [3] = '{0, 0, 0};

	ray_t ray_queue [$];
	point_t expected_points [$];
	ray_t cur_ray;
	int gap_left = 0;
	bit gaps_on = 1;
	bit launch;
	int errors = 0;
	int accepted = 0;
	int hits_seen = 0;
	int sats_seen = 0;
	int cycles = 0;

	function automatic logic signed [127:0] scaled_term(logic [30:0] sc,
			logic signed [127:0] x);
		logic signed [127:0] p;
		p = ($signed({97'b0, sc}) * x) >>> FRAC;
		if (p > TERM_MAX) return TERM_MAX;
		if (p < TERM_MIN) return TERM_MIN;
		return p;
	endfunction

	function automatic bit norm_fits(logic signed [127:0] x);
		return x >= -NORM_LIM && x < NORM_LIM;
	endfunction

	function automatic point_t trace_ray(ray_t r);
		logic signed [127:0] o [3], v [3], dl [3], a [3], b [3];
		logic signed [127:0] c1, c2, c3, c1s, c2s, c3s, det, n, qs, p;
		logic [127:0] root, trial, quo, mv, mn;
		logic signed [31:0] pt [3];
		int k;
		point_t res;
		res = '0;
		o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
		v[0] = r.dx; v[1] = r.dy; v[2] = r.dz;
		for (int i = 0; i < 3; i++)
			dl[i] = o[i] - cfg_center[i];
		a[0] = v[0];
		b[0] = dl[0];
		a[1] = scaled_term(cfg_scale_y, v[1]);
		b[1] = scaled_term(cfg_scale_y, dl[1]);
		a[2] = scaled_term(cfg_scale_z, v[2]);
		b[2] = scaled_term(cfg_scale_z, dl[2]);
		c1 = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
		c2 = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
		c3 = b[0] * b[0] + b[1] * b[1] + b[2] * b[2]
			- $signed({97'b0, cfg_radius}) * $signed({97'b0, cfg_radius});
		if (c1 == 0) return res;
		k = 0;
		while (!(norm_fits(c1 >>> k) && norm_fits(c2 >>> k) && norm_fits(c3 >>> k)))
			k++;
		c1s = c1 >>> k;
		c2s = c2 >>> k;
		c3s = c3 >>> k;
		if (c1s <= 0) return res;
		det = c2s * c2s - c1s * c3s;
		if (det < 0) return res;
		root = 0;
		for (int bi = 63; bi >= 0; bi--) begin
			trial = root | (128'd1 << bi);
			if (trial * trial <= det) root = trial;
		end
		n = r.smaller ? -c2s - $signed(root) : -c2s + $signed(root);
		mn = (n < 0) ? -n : n;
		for (int i = 0; i < 3; i++) begin
			mv = (v[i] < 0) ? -v[i] : v[i];
			quo = (mv * mn) / c1s;
			if (quo > (128'd1 << 62)) quo = 128'd1 << 62;
			qs = ((v[i] < 0) != (n < 0)) ? -$signed(quo) : $signed(quo);
			p = o[i] + qs;
			if (p > COORD_MAX) begin
				p = COORD_MAX;
				res.sat = 1;
			end
			if (p < COORD_MIN) begin
				p = COORD_MIN;
				res.sat = 1;
			end
			pt[i] = p[31:0];
		end
		res.hit = 1;
		res.px = pt[0];
		res.py = pt[1];
		res.pz = pt[2];
		return res;
	endfunction

	// request driver: hold start until taken, idle in random bursts
	always @(posedge clk) begin
		if (arst_n) begin
			launch = 0;
			if (start && !busy) begin
				expected_points.push_back(trace_ray(cur_ray));
				accepted++;
			end
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (ray_queue.size() > 0) begin
					if (gaps_on && $urandom_range(0, 5) == 0) begin
						gap_left = $urandom_range(1, 13);
					end else begin
						cur_ray = ray_queue.pop_front();
						launch = 1;
						origin_x <= cur_ray.ox;
						origin_y <= cur_ray.oy;
						origin_z <= cur_ray.oz;
						dir_x <= cur_ray.dx;
						dir_y <= cur_ray.dy;
						dir_z <= cur_ray.dz;
						take_smaller_root <= cur_ray.smaller;
					end
				end
				start <= launch;
			end
		end
	end

	task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_val, act_val);
			errors++;
		end
	endtask

	// result monitor
	always @(posedge clk) begin
		point_t want;
		if (arst_n && done) begin
			if (expected_points.size() == 0) begin
				$display("%0t: unexpected result, expected none, got hit=%b", $time, hit);
				errors++;
			end else begin
				want = expected_points.pop_front();
				check_field("hit", 32'(want.hit), 32'(hit));
				check_field("point_x", want.px, point_x);
				check_field("point_y", want.py, point_y);
				check_field("point_z", want.pz, point_z);
				check_field("saturated", 32'(want.sat), 32'(saturated));
				if (hit) hits_seen++;
				if (saturated) sats_seen++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				expected_points.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic apb_write(int index, logic [31:0] value);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= 5'(index * 4);
		pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (index)
			REG_RADIUS: cfg_radius = value[30:0];
			REG_SCALE_Y: cfg_scale_y = value[30:0];
			REG_SCALE_Z: cfg_scale_z = value[30:0];
			REG_CENTER_X: cfg_center[0] = value;
			REG_CENTER_Y: cfg_center[1] = value;
			REG_CENTER_Z: cfg_center[2] = value;
			default: ;
		endcase
	endtask

	task automatic configure(logic [31:0] rad, logic [31:0] sy, logic [31:0] sz,
			logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
		apb_write(REG_RADIUS, rad);
		apb_write(REG_SCALE_Y, sy);
		apb_write(REG_SCALE_Z, sz);
		apb_write(REG_CENTER_X, cx);
		apb_write(REG_CENTER_Y, cy);
		apb_write(REG_CENTER_Z, cz);
	endtask

	task automatic add_ray(int ox, int oy, int oz, int dx, int dy, int dz, bit sm);
		ray_t r;
		r = '{ox, oy, oz, dx, dy, dz, sm};
		ray_queue.push_back(r);
	endtask

	function automatic int rand_mag();
		return int'($urandom) >>> $urandom_range(0, 31);
	endfunction

	function automatic int near_center(int axis);
		longint ofs;
		ofs = longint'($urandom_range(0, cfg_radius)) - longint'(cfg_radius / 2);
		return int'(longint'(cfg_center[axis]) + ofs);
	endfunction

	// mostly rays that start inside or aim at the body, the rest noise
	task automatic add_random_rays(int count);
		int mode, ox, oy, oz;
		repeat (count) begin
			mode = $urandom_range(0, 9);
			if (mode < 2) begin
				add_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom_range(0, 1));
			end else if (mode < 6) begin
				add_ray(near_center(0), near_center(1), near_center(2),
					rand_mag(), rand_mag(), rand_mag(), $urandom_range(0, 1));
			end else if (mode < 9) begin
				ox = rand_mag();
				oy = rand_mag();
				oz = rand_mag();
				add_ray(ox, oy, oz,
					cfg_center[0] - ox + (rand_mag() >>> 8),
					cfg_center[1] - oy + (rand_mag() >>> 8),
					cfg_center[2] - oz + (rand_mag() >>> 8), $urandom_range(0, 1));
			end else begin
				add_ray(rand_mag(), rand_mag(), rand_mag(), rand_mag(), rand_mag(),
					rand_mag(), $urandom_range(0, 1));
			end
		end
	endtask

	task automatic drain();
		while (ray_queue.size() > 0 || gap_left > 0 || start || expected_points.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1;
		configure(ONE, ONE, ONE, 0, 0, 0);

		// unit sphere: chords both ways, zero direction, tangent, miss, extremes
		add_ray(0, 0, 0, ONE, 0, 0, 0);
		add_ray(0, 0, 0, ONE, 0, 0, 1);
		add_ray(0, 0, 0, 0, -ONE, ONE / 2, 1);
		add_ray(ONE / 4, ONE / 4, 0, 0, 0, 0, 0);
		add_ray(-2 * ONE, ONE, 0, ONE, 0, 0, 1);
		add_ray(-2 * ONE, ONE, 0, ONE, 0, 0, 0);
		add_ray(-2 * ONE, 2 * ONE, 0, ONE, 0, 0, 0);
		add_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
		add_ray(32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000, 1);
		add_ray(32'h7fffffff, 32'h80000000, 0, 32'h80000000, 32'h7fffffff, 1, 0);
		add_ray(0, 0, 0, 1, 1, 1, 1);
		add_ray(0, 0, 0, 32'h7fffffff, 0, 0, 1);
		add_ray(32'h7fff0000, 0, 0, -1, 0, 0, 0);
		add_ray(0, 0, -3 * ONE, 0, 0, ONE, 1);
		add_random_rays(300);
		drain();

		configure($urandom_range(1 << 12, 1 << 24), $urandom_range(1 << 12, 1 << 20),
			$urandom_range(1 << 12, 1 << 20), rand_mag() >>> 6, rand_mag() >>> 6,
			rand_mag() >>> 6);
		add_random_rays(400);
		drain();

		configure(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h80000000, 32'h7fffffff, 32'h80000000);
		add_random_rays(200);
		drain();

		configure(0, 0, 0, 32'h7fffffff, 32'h80000000, 0);
		add_random_rays(200);
		drain();

		// write to an unmapped slot must leave everything alone
		configure(32'hffffffff, $urandom, $urandom, rand_mag(), rand_mag(), rand_mag());
		apb_write(UNMAPPED_INDEX, $urandom);
		add_random_rays(400);
		drain();

		configure($urandom_range(1 << 14, 1 << 22), ONE, $urandom_range(1 << 15, 1 << 18),
			rand_mag() >>> 8, rand_mag() >>> 8, rand_mag() >>> 8);
		gaps_on = 0;
		add_random_rays(400);
		drain();

		$display("%0d rays over six register settings, %0d hits, %0d saturated",
			accepted, hits_seen, sats_seen);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", errors);
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+sv
sv/rei_pkg.sv
sv/rei_mul.sv
sv/rei_udiv.sv
sv/ray_ellipsoid_intersection.sv
sim/ray_ellipsoid_intersection_test.sv
